// ===== sv/cbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_ROM_READ    = 3'd0,
    STAT_RAM_READ    = 3'd1,
    STAT_RAM_OFF     = 3'd2,
    STAT_CTRL_WRITE  = 3'd3,
    STAT_RAM_WRITE   = 3'd4,
    STAT_WR_IGNORED  = 3'd5,
    STAT_BAD_ADDRESS = 3'd6
  } status_e;

  // Configuration register indexes
  localparam logic [7:0] CFG_ROM_BANK_COUNT = 8'd0;
  localparam logic [7:0] CFG_RAM_SIZE       = 8'd1;

  // Address regions, decoded from address[15:13]
  localparam logic [2:0] REG_RAM_EN   = 3'd0;
  localparam logic [2:0] REG_LOW_BANK = 3'd1;
  localparam logic [2:0] REG_UP_BITS  = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_EXT_RAM  = 3'd5;

  // Field widths
  localparam int ROM_FIELD_W = 21;
  localparam int DVD_W       = 15;  // widest dividend: RAM offset
  localparam int DSR_W       = 16;  // widest divisor: RAM size
  localparam int DIV_STEPS   = DVD_W;

  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [7:0] RAM_OFF_VAL = 8'hFF;

endpackage

// ===== sv/cbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/cartridge_bank_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// ROM/RAM bank switching mapper serving one CPU bus access per transfer.
// ----------------------------------------------------------------------------
// One access is handled at a time. Control writes, ignored writes, bad
// addresses and RAM-off reads pass straight to the hand-over state. Banked
// ROM reads and RAM accesses run a 15-step restoring modulo on one shared
// compare/subtract unit, then one memory state, and RAM reads add a read
// state. Mode-0 reads of the low window skip the modulo. The input is ready
// again at the edge where the result is first offered. After reset a
// clearing pass zeroes the cartridge RAM, one byte a cycle over all RAM_DEPTH
// bytes, while no access is taken; configuration writes are always taken.
// The result register lets a new access enter while the previous result
// waits.
// ----------------------------------------------------------------------------
module cartridge_bank_controller
  import cbc_pkg::*;
#(
  parameter int RAM_DEPTH      = 32768,
  parameter int ROM_ADDR_WIDTH = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
  input  logic        s_axis_tuser,   // write flag: 1 write, 0 read
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // rom_address[20:0], read_data[28:21], zero
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IDX_W = $clog2(RAM_DEPTH);
  localparam logic [DSR_W-1:0] DEPTH_SZ = DSR_W'(RAM_DEPTH);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(RAM_DEPTH - 1);
  localparam logic [3:0]       DIV_LAST = 4'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MEM,
    ST_RD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    JOB_ROM,
    JOB_RAM_RD,
    JOB_RAM_WR
  } job_e;

  // Configuration
  logic [7:0]       bank_cnt_q;
  logic [DSR_W-1:0] ram_size_q;

  // Mapper state
  logic       ram_en_q, ram_en_d;
  logic [4:0] low_bank_q, low_bank_d;
  logic [1:0] up_bits_q, up_bits_d;
  logic       adv_mode_q, adv_mode_d;

  // Sequencer and shared divider
  state_e           st_q, st_d;
  job_e             job_q, job_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [13:0]      off_q, off_d;
  logic [7:0]       wdata_q, wdata_d;

  // Pending result
  status_e                 res_stat_q, res_stat_d;
  logic [ROM_FIELD_W-1:0]  res_rom_q, res_rom_d;
  logic [7:0]              res_rdata_q, res_rdata_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  status_e                 out_stat_q, out_stat_d;
  logic [ROM_FIELD_W-1:0]  out_rom_q, out_rom_d;
  logic [7:0]              out_rdata_q, out_rdata_d;

  // Decode helpers
  logic [15:0]      in_addr;
  logic [7:0]       in_data;
  logic [2:0]       in_region;
  logic [DSR_W-1:0] size_eff;
  logic             ram_ok;
  logic [7:0]       bank_div;
  logic             in_xfer;

  // Shared compare/subtract unit
  logic [DSR_W:0]   step_t;
  logic [DSR_W:0]   step_sub;
  logic             step_ge;

  // ROM address assembly
  logic [ROM_FIELD_W-1:0]    rom_full;
  logic [ROM_ADDR_WIDTH-1:0] rom_trunc;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  assign in_addr   = s_axis_tdata[15:0];
  assign in_data   = s_axis_tdata[23:16];
  assign in_region = in_addr[15:13];
  assign size_eff  = (ram_size_q > DEPTH_SZ) ? DEPTH_SZ : ram_size_q;
  assign ram_ok    = ram_en_q && (size_eff != '0);
  assign bank_div  = (bank_cnt_q == 8'd0) ? 8'd1 : bank_cnt_q;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign step_t   = {rem_q, dvd_q[DVD_W-1]};
  assign step_ge  = step_t >= {1'b0, dsr_q};
  assign step_sub = step_t - {1'b0, dsr_q};

  assign rom_full  = {rem_q[6:0], off_q};
  assign rom_trunc = rom_full[ROM_ADDR_WIDTH-1:0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {3'b000, out_rdata_q, out_rom_q};

  // Drive the RAM port: clearing pass or the current access
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rem_q[IDX_W-1:0];
    ram_wdata = wdata_q;
    if (st_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = 8'd0;
    end else if (st_q == ST_MEM && job_q == JOB_RAM_WR) begin
      ram_we = 1'b1;
    end
  end

  cbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    st_d        = st_q;
    job_d       = job_q;
    dvd_d       = dvd_q;
    dsr_d       = dsr_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    off_d       = off_q;
    wdata_d     = wdata_q;
    ram_en_d    = ram_en_q;
    low_bank_d  = low_bank_q;
    up_bits_d   = up_bits_q;
    adv_mode_d  = adv_mode_q;
    res_stat_d  = res_stat_q;
    res_rom_d   = res_rom_q;
    res_rdata_d = res_rdata_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_rom_d   = out_rom_q;
    out_rdata_d = out_rdata_q;

    // Drop the result once it is taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          res_stat_d  = STAT_BAD_ADDRESS;
          res_rom_d   = '0;
          res_rdata_d = 8'd0;
          rem_d       = '0;
          cnt_d       = '0;
          off_d       = in_addr[13:0];
          wdata_d     = in_data;
          st_d        = ST_DONE;
          if (s_axis_tuser) begin
            // Bus write
            unique case (in_region)
              REG_RAM_EN: begin
                ram_en_d   = (in_data[3:0] == RAM_EN_KEY);
                res_stat_d = STAT_CTRL_WRITE;
              end
              REG_LOW_BANK: begin
                low_bank_d = (in_data[4:0] == 5'd0) ? 5'd1 : in_data[4:0];
                res_stat_d = STAT_CTRL_WRITE;
              end
              REG_UP_BITS: begin
                up_bits_d  = in_data[1:0];
                res_stat_d = STAT_CTRL_WRITE;
              end
              REG_MODE: begin
                adv_mode_d = in_data[0];
                res_stat_d = STAT_CTRL_WRITE;
              end
              REG_EXT_RAM: begin
                if (ram_ok) begin
                  job_d = JOB_RAM_WR;
                  dvd_d = {(adv_mode_q ? up_bits_q : 2'b00), in_addr[12:0]};
                  dsr_d = size_eff;
                  st_d  = ST_DIV;
                end else begin
                  res_stat_d = STAT_WR_IGNORED;
                end
              end
              default: begin
                res_stat_d = STAT_BAD_ADDRESS;
              end
            endcase
          end else begin
            // Bus read
            unique case (in_region)
              REG_RAM_EN, REG_LOW_BANK: begin
                job_d = JOB_ROM;
                dvd_d = {8'd0, up_bits_q, 5'd0};
                dsr_d = {8'd0, bank_div};
                st_d  = adv_mode_q ? ST_DIV : ST_MEM;
              end
              REG_UP_BITS, REG_MODE: begin
                job_d = JOB_ROM;
                dvd_d = {8'd0, up_bits_q, low_bank_q};
                dsr_d = {8'd0, bank_div};
                st_d  = ST_DIV;
              end
              REG_EXT_RAM: begin
                if (ram_ok) begin
                  job_d = JOB_RAM_RD;
                  dvd_d = {(adv_mode_q ? up_bits_q : 2'b00), in_addr[12:0]};
                  dsr_d = size_eff;
                  st_d  = ST_DIV;
                end else begin
                  res_stat_d  = STAT_RAM_OFF;
                  res_rdata_d = RAM_OFF_VAL;
                end
              end
              default: begin
                res_stat_d = STAT_BAD_ADDRESS;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        // One restoring step: shift in a dividend bit, subtract if it fits
        rem_d = step_ge ? step_sub[DSR_W-1:0] : step_t[DSR_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          st_d = ST_MEM;
        end
      end
      ST_MEM: begin
        unique case (job_q)
          JOB_ROM: begin
            res_stat_d = STAT_ROM_READ;
            res_rom_d  = ROM_FIELD_W'(rom_trunc);
            st_d       = ST_DONE;
          end
          JOB_RAM_WR: begin
            res_stat_d = STAT_RAM_WRITE;
            st_d       = ST_DONE;
          end
          default: begin
            st_d = ST_RD;
          end
        endcase
      end
      ST_RD: begin
        res_stat_d  = STAT_RAM_READ;
        res_rdata_d = ram_rdata;
        st_d        = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_rom_d   = res_rom_q;
          out_rdata_d = res_rdata_q;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      job_q       <= JOB_ROM;
      dvd_q       <= '0;
      dsr_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      clr_q       <= '0;
      off_q       <= '0;
      wdata_q     <= '0;
      ram_en_q    <= 1'b0;
      low_bank_q  <= 5'd1;
      up_bits_q   <= 2'd0;
      adv_mode_q  <= 1'b0;
      res_stat_q  <= STAT_BAD_ADDRESS;
      res_rom_q   <= '0;
      res_rdata_q <= '0;
      out_valid_q <= 1'b0;
      out_stat_q  <= STAT_BAD_ADDRESS;
      out_rom_q   <= '0;
      out_rdata_q <= '0;
    end else begin
      st_q        <= st_d;
      job_q       <= job_d;
      dvd_q       <= dvd_d;
      dsr_q       <= dsr_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      off_q       <= off_d;
      wdata_q     <= wdata_d;
      ram_en_q    <= ram_en_d;
      low_bank_q  <= low_bank_d;
      up_bits_q   <= up_bits_d;
      adv_mode_q  <= adv_mode_d;
      res_stat_q  <= res_stat_d;
      res_rom_q   <= res_rom_d;
      res_rdata_q <= res_rdata_d;
      out_valid_q <= out_valid_d;
      out_stat_q  <= out_stat_d;
      out_rom_q   <= out_rom_d;
      out_rdata_q <= out_rdata_d;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_cnt_q <= 8'd2;
      ram_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROM_BANK_COUNT: bank_cnt_q <= cfg_data_i[7:0];
        CFG_RAM_SIZE:       ram_size_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Partial remainder always stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (rem_q < dsr_q))
    else $error("remainder not below divisor");

  // RAM accesses land inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MEM && job_q != JOB_ROM) |-> (rem_q < DEPTH_SZ))
    else $error("RAM index out of range");

  // A new result appears only from the hand-over state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == ST_DONE))
    else $error("result without hand-over");

  // Only ROM reads carry a ROM address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_ROM_READ) |-> (m_axis_tdata[20:0] == '0))
    else $error("ROM address on non-ROM result");

  // No access is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input ready while clearing");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression of the cartridge bank controller. Bus accesses
// stream in from a queue, and every result is compared with a behavioral
// mapper that tracks bank registers, banking mode and cartridge RAM contents.
// Directed accesses hit the window edges and the corner cases, and random
// phases under several ROM and RAM sizes follow.
// ----------------------------------------------------------------------------
module tb;
  import cbc_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 140;
  localparam int LONG_HOLD     = 400;
  localparam int RAM_BYTES     = 32768;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_access_t;

  typedef struct packed {
    status_e     status;
    logic [20:0] rom_addr;
    logic [7:0]  rdata;
  } map_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  cartridge_bank_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mapper state mirrored by the testbench
  logic [7:0]  bank_count = 8'd2;
  logic [15:0] ram_size = 16'd0;
  logic        ram_on = 1'b0;
  logic [4:0]  low_bank = 5'd1;
  logic [1:0]  upper_bits = 2'd0;
  logic        banked_mode = 1'b0;
  logic [7:0]  shadow_ram [0:RAM_BYTES-1];

  bus_access_t bus_accesses [$];
  map_result_t mapped_results [$];

  logic        access_taken = 1'b0;
  bit          quiet_run = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          error_count = 0;
  int          access_count = 0;
  int          cfg_writes = 0;
  int          status_seen [7];

  // Apply one access to the mirrored state and return the result it gives
  function automatic map_result_t map_access(logic wr, logic [15:0] addr,
                                             logic [7:0] data);
    map_result_t r;
    int unsigned divisor, eff_size, ram_idx, bank;
    bit          ram_ok;
    r.status   = STAT_BAD_ADDRESS;
    r.rom_addr = '0;
    r.rdata    = '0;
    divisor  = (bank_count == 0) ? 1 : bank_count;
    eff_size = (ram_size > RAM_BYTES) ? RAM_BYTES : ram_size;
    ram_ok   = ram_on && (eff_size != 0);
    ram_idx  = addr - 16'hA000;
    if (banked_mode) ram_idx = ram_idx + upper_bits * 32'h2000;
    if (eff_size != 0) ram_idx = ram_idx % eff_size;
    if (wr == ACC_WRITE) begin
      case (addr[15:13])
        REG_RAM_EN: begin
          ram_on   = (data[3:0] == RAM_EN_KEY);
          r.status = STAT_CTRL_WRITE;
        end
        REG_LOW_BANK: begin
          low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
          r.status = STAT_CTRL_WRITE;
        end
        REG_UP_BITS: begin
          upper_bits = data[1:0];
          r.status   = STAT_CTRL_WRITE;
        end
        REG_MODE: begin
          banked_mode = data[0];
          r.status    = STAT_CTRL_WRITE;
        end
        REG_EXT_RAM: begin
          if (ram_ok) begin
            shadow_ram[ram_idx] = data;
            r.status = STAT_RAM_WRITE;
          end else begin
            r.status = STAT_WR_IGNORED;
          end
        end
        default: r.status = STAT_BAD_ADDRESS;
      endcase
    end else begin
      case (addr[15:13])
        REG_RAM_EN, REG_LOW_BANK: begin
          // low window: bank 0 unless the mode selects the upper bits
          bank = banked_mode ? ({upper_bits, 5'd0} % divisor) : 0;
          r.rom_addr = 21'(bank * 32'h4000 + addr[13:0]);
          r.status   = STAT_ROM_READ;
        end
        REG_UP_BITS, REG_MODE: begin
          bank = {upper_bits, low_bank} % divisor;
          r.rom_addr = 21'(bank * 32'h4000 + addr[13:0]);
          r.status   = STAT_ROM_READ;
        end
        REG_EXT_RAM: begin
          if (ram_ok) begin
            r.rdata  = shadow_ram[ram_idx];
            r.status = STAT_RAM_READ;
          end else begin
            r.rdata  = RAM_OFF_VAL;
            r.status = STAT_RAM_OFF;
          end
        end
        default: r.status = STAT_BAD_ADDRESS;
      endcase
    end
    return r;
  endfunction

  // Draw a random access, mostly well-formed traffic with some noise
  function automatic bus_access_t random_access();
    bus_access_t a;
    int unsigned pick;
    pick   = $urandom_range(0, 99);
    a.wr   = ACC_READ;
    a.addr = 16'($urandom);
    a.data = 8'($urandom);
    if (pick < 30) begin
      // control write, RAM enable key favored
      a.wr   = ACC_WRITE;
      a.addr = 16'($urandom_range(0, 16'h7FFF));
      if (a.addr[15:13] == REG_RAM_EN && $urandom_range(0, 3) != 0)
        a.data[3:0] = RAM_EN_KEY;
    end else if (pick < 55) begin
      a.addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 90) begin
      // RAM access, often in a small window so reads hit earlier writes
      a.wr   = 1'($urandom_range(0, 1));
      a.addr = 16'(16'hA000 + (($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
                                                             : $urandom_range(0, 16'h1FFF)));
    end else begin
      a.wr = 1'($urandom_range(0, 1));
    end
    return a;
  endfunction

  task automatic queue_access(input logic wr, input logic [15:0] addr,
                              input logic [7:0] data);
    bus_access_t a;
    a.wr   = wr;
    a.addr = addr;
    a.data = data;
    bus_accesses.push_back(a);
  endtask

  // Write one configuration register, only called while the block is idle
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ROM_BANK_COUNT) bank_count = val[7:0];
    else if (idx == CFG_RAM_SIZE) ram_size = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every queued access has come back
  task automatic drain();
    while (bus_accesses.size() != 0 || s_axis_tvalid || mapped_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Access driver: offer queued accesses with random gaps
  always @(negedge clk_i) begin : access_driver
    logic        nxt_valid;
    logic [23:0] nxt_data;
    logic        nxt_user;
    bus_access_t a;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    nxt_user  = s_axis_tuser;
    if (!s_axis_tvalid || access_taken) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (bus_accesses.size() != 0) begin
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
        end else begin
          a = bus_accesses.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = {a.data, a.addr};
          nxt_user  = a.wr;
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
    s_axis_tuser  <= nxt_user;
  end

  // Result sink: random stall bursts plus one long hold-off
  always @(negedge clk_i) begin : result_sink
    logic rdy;
    rdy = 1'b1;
    if (long_hold_req && !long_hold_done) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  // Scoreboard: check results, then predict newly accepted accesses
  always @(posedge clk_i) begin : scoreboard
    map_result_t want, got;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("cartridge_bank_controller regression: fail");
      $finish;
    end else begin
      access_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.status   = status_e'(m_axis_tuser);
        got.rom_addr = m_axis_tdata[20:0];
        got.rdata    = m_axis_tdata[28:21];
        if (mapped_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, got.status);
          error_count++;
        end else begin
          want = mapped_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
            error_count++;
          end
          if (got.rom_addr !== want.rom_addr) begin
            $display("%0t: rom_address expected %h actual %h", $time,
                     want.rom_addr, got.rom_addr);
            error_count++;
          end
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rdata,
                     got.rdata);
            error_count++;
          end
          if (int'(want.status) < 7) status_seen[want.status]++;
        end
      end
      if (rst_ni && s_axis_tvalid && s_axis_tready) begin
        want = map_access(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
        mapped_results.push_back(want);
        access_count++;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int unsigned phase_banks [8] = '{128, 1, 255, 37, 64, 3, 2, 128};
    int unsigned phase_sizes [8] = '{32768, 1, 2048, 1000, 8192, 3, 0, 32768};
    foreach (shadow_ram[i]) shadow_ram[i] = 8'h00;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Window edges, control writes and unmapped space with no RAM present
    queue_access(ACC_READ,  16'h0000, 8'h00);
    queue_access(ACC_READ,  16'h3FFF, 8'hFF);
    queue_access(ACC_READ,  16'h4000, 8'h00);
    queue_access(ACC_READ,  16'h7FFF, 8'h00);
    queue_access(ACC_WRITE, 16'h0000, 8'h0A);
    queue_access(ACC_READ,  16'hA000, 8'h00);
    queue_access(ACC_WRITE, 16'hA000, 8'h55);
    queue_access(ACC_READ,  16'h8000, 8'h00);
    queue_access(ACC_WRITE, 16'h9FFF, 8'hFF);
    queue_access(ACC_READ,  16'hC000, 8'h00);
    queue_access(ACC_WRITE, 16'hFFFF, 8'hFF);
    queue_access(ACC_WRITE, 16'h2000, 8'h00);
    queue_access(ACC_READ,  16'h4001, 8'h00);
    queue_access(ACC_WRITE, 16'h3FFF, 8'hFF);
    queue_access(ACC_WRITE, 16'h4000, 8'hFF);
    queue_access(ACC_READ,  16'h7FFF, 8'h00);
    queue_access(ACC_WRITE, 16'h6000, 8'h01);
    queue_access(ACC_READ,  16'h0000, 8'h00);
    queue_access(ACC_WRITE, 16'h7FFF, 8'hFE);
    queue_access(ACC_READ,  16'h1234, 8'h00);
    drain();

    // Zero bank count and oversized RAM
    write_reg(CFG_ROM_BANK_COUNT, 16'd0);
    write_reg(CFG_RAM_SIZE, 16'hFFFF);
    queue_access(ACC_WRITE, 16'h1FFF, 8'h5A);
    queue_access(ACC_WRITE, 16'hA000, 8'hFF);
    queue_access(ACC_WRITE, 16'hBFFF, 8'h00);
    queue_access(ACC_WRITE, 16'h6000, 8'hFF);
    queue_access(ACC_WRITE, 16'hBFFF, 8'hC3);
    queue_access(ACC_READ,  16'hBFFF, 8'h00);
    queue_access(ACC_READ,  16'h7ABC, 8'h00);
    queue_access(ACC_READ,  16'h2000, 8'h00);
    queue_access(ACC_WRITE, 16'h6000, 8'h00);
    queue_access(ACC_READ,  16'hA000, 8'h00);
    queue_access(ACC_READ,  16'hB123, 8'h00);
    queue_access(ACC_WRITE, 16'h0000, 8'hA5);
    queue_access(ACC_READ,  16'hA000, 8'h00);
    drain();

    // Random phases under varied ROM and RAM sizes
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_ROM_BANK_COUNT, 16'(phase_banks[ph]));
      write_reg(CFG_RAM_SIZE, 16'(phase_sizes[ph]));
      if (ph == 4) long_hold_req = 1'b1;
      if (ph == 7) quiet_run = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) bus_accesses.push_back(random_access());
      drain();
    end

    $display("Ran %0d bus accesses over %0d register writes and 10 size settings.",
             access_count, cfg_writes);
    $display("Seen: rom %0d, ram read %0d, ram off %0d, ctrl %0d, ram write %0d, %s %0d",
             status_seen[STAT_ROM_READ], status_seen[STAT_RAM_READ],
             status_seen[STAT_RAM_OFF], status_seen[STAT_CTRL_WRITE],
             status_seen[STAT_RAM_WRITE], "ignored/bad",
             status_seen[STAT_WR_IGNORED] + status_seen[STAT_BAD_ADDRESS]);
    if (error_count == 0) begin
      $display("cartridge_bank_controller regression: pass");
    end else begin
      $display("cartridge_bank_controller regression: fail");
    end
    $finish;
  end

endmodule
